// File: design/assert_macros.svh
// assertion macros used by the angle core top level
// expects i_clk and i_rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression must hold at every clock edge outside reset
`define ABV_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ABV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ABV_ASSERT(label, expr)
`define ABV_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// File: design/abv_pkg.sv
// package for the angle core: widths, cordic angle table, pipeline data types
// no dependencies
package abv_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int TABLE_LEN  = 24;
    localparam int CELL_COUNT = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int SHIFT_W    = $clog2(CELL_COUNT);
    localparam int TURN_W     = 32;
    // difference bits, guard bits and headroom for the cordic gain
    localparam int VEC_W      = COORD_WIDTH + 1 + CORDIC_STAGES + 3;

    localparam logic [TURN_W-1:0] HALF_TURN = {1'b1, {(TURN_W-1){1'b0}}};

    // atan(2^-i) as a fraction of a full turn
    localparam logic [TURN_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic                     zero;
        logic [TURN_W-1:0]        z;
        logic signed [VEC_W-1:0]  u;
        logic signed [VEC_W-1:0]  v;
    } t_vec;

    typedef struct packed {
        t_vec a;
        t_vec b;
    } t_pair;

endpackage

// File: design/angle_between_vectors_core.sv
// top level of the angle core: input stage, chain of cordic cells, output register
// depends on abv_pkg, abv_prep, abv_cell and assert_macros.svh
//
//   channel | signals                                 | direction
//   in      | i_valid, o_ready, i_origin_x..i_second_y | point triple in
//   out     | o_valid, i_ready, o_angle_units          | angle out
//
// the path is one input stage, one cell per cordic micro-rotation and one output
// register with rounding.
// one triple is taken per cycle while no stall holds the chain; each stage holds one item and moves it on
// when the stage after it is empty or moving, so bubbles close up under a stall.
// synchronous active-low reset clears all stage valid bits.
`include "assert_macros.svh"

module angle_between_vectors_core import abv_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [COORD_WIDTH-1:0]  i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]  i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]  i_first_x,
    input  logic signed [COORD_WIDTH-1:0]  i_first_y,
    input  logic signed [COORD_WIDTH-1:0]  i_second_x,
    input  logic signed [COORD_WIDTH-1:0]  i_second_y,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ANGLE_BITS:0]            o_angle_units
);

    localparam logic [ANGLE_BITS:0] FULL_TURN  = {1'b1, {ANGLE_BITS{1'b0}}};
    localparam logic [TURN_W:0]     ROUND_HALF = (TURN_W+1)'(1) << (TURN_W - 1 - ANGLE_BITS);

    logic  chain_valid [CELL_COUNT+1];
    logic  chain_ready [CELL_COUNT+1];
    t_pair chain_data  [CELL_COUNT+1];

    logic                  r_out_valid;
    logic [ANGLE_BITS:0]   r_out_angle;
    logic [ANGLE_BITS:0]   n_out_angle;
    logic                  out_ready;

    logic [TURN_W-1:0]     za, zb, diff;
    logic [TURN_W:0]       rounded_sum;
    logic [ANGLE_BITS-1:0] rounded;

    abv_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .o_valid    (chain_valid[0]),
        .i_ready    (chain_ready[0]),
        .o_data     (chain_data[0])
    );

    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        abv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .i_shift (SHIFT_W'(k)),
            .i_atan  (ATAN_TURNS[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    assign out_ready               = !r_out_valid || i_ready;
    assign chain_ready[CELL_COUNT] = out_ready;

    // zero vectors point at direction 0; equal directions give a full turn
    always_comb begin
        za          = chain_data[CELL_COUNT].a.zero ? '0 : chain_data[CELL_COUNT].a.z;
        zb          = chain_data[CELL_COUNT].b.zero ? '0 : chain_data[CELL_COUNT].b.z;
        diff        = za - zb;
        rounded_sum = {1'b0, diff} + ROUND_HALF;
        rounded     = rounded_sum[TURN_W-1 -: ANGLE_BITS];
        n_out_angle = (rounded == '0) ? FULL_TURN : {1'b0, rounded};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= chain_valid[CELL_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && chain_valid[CELL_COUNT]) begin
            r_out_angle <= n_out_angle;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_angle_units = r_out_angle;

    `ABV_ASSERT_IMPL(a_angle_nonzero, o_valid, o_angle_units != '0)
    `ABV_ASSERT_IMPL(a_angle_max, o_valid, o_angle_units <= FULL_TURN)
    `ABV_ASSERT_IMPL(a_empty_takes, !o_valid, o_ready)
    `ABV_ASSERT_IMPL(a_chain_ready, out_ready, chain_ready[0])

endmodule

// File: design/abv_prep.sv
// input stage: shifts both points to the origin and sets up the cordic start values
// depends on abv_pkg
module abv_prep import abv_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [COORD_WIDTH-1:0]  i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]  i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]  i_first_x,
    input  logic signed [COORD_WIDTH-1:0]  i_first_y,
    input  logic signed [COORD_WIDTH-1:0]  i_second_x,
    input  logic signed [COORD_WIDTH-1:0]  i_second_y,
    output logic                           o_valid,
    input  logic                           i_ready,
    output t_pair                          o_data
);

    function automatic t_vec start_vec(logic signed [COORD_WIDTH:0] dx,
                                       logic signed [COORD_WIDTH:0] dy);
        t_vec                    r;
        logic signed [VEC_W-1:0] x_w;
        logic signed [VEC_W-1:0] y_w;
        x_w    = {{(VEC_W-COORD_WIDTH-1){dx[COORD_WIDTH]}}, dx};
        y_w    = {{(VEC_W-COORD_WIDTH-1){dy[COORD_WIDTH]}}, dy};
        r.zero = (dx == '0) && (dy == '0);
        r.u    = y_w <<< CORDIC_STAGES;
        r.v    = x_w <<< CORDIC_STAGES;
        r.z    = '0;
        // lower half plane: flip the vector and start at a half turn
        if (dy[COORD_WIDTH]) begin
            r.u = -(y_w <<< CORDIC_STAGES);
            r.v = -(x_w <<< CORDIC_STAGES);
            r.z = HALF_TURN;
        end
        return r;
    endfunction

    logic signed [COORD_WIDTH:0] ax, ay, bx, by;
    logic                        r_valid;
    t_pair                       r_data;
    t_pair                       n_data;

    always_comb begin
        ax       = {i_first_x[COORD_WIDTH-1], i_first_x} - {i_origin_x[COORD_WIDTH-1], i_origin_x};
        ay       = {i_first_y[COORD_WIDTH-1], i_first_y} - {i_origin_y[COORD_WIDTH-1], i_origin_y};
        bx       = {i_second_x[COORD_WIDTH-1], i_second_x}
                   - {i_origin_x[COORD_WIDTH-1], i_origin_x};
        by       = {i_second_y[COORD_WIDTH-1], i_second_y}
                   - {i_origin_y[COORD_WIDTH-1], i_origin_y};
        n_data.a = start_vec(ax, ay);
        n_data.b = start_vec(bx, by);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: design/abv_cell.sv
// one cordic vectoring cell: a single micro-rotation of both vectors
// depends on abv_pkg
module abv_cell import abv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_pair              i_data,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic [TURN_W-1:0]  i_atan,
    output logic               o_valid,
    input  logic               i_ready,
    output t_pair              o_data
);

    function automatic t_vec rotate(t_vec s, logic [SHIFT_W-1:0] sh,
                                    logic [TURN_W-1:0] atan);
        t_vec                    r;
        logic signed [VEC_W-1:0] du;
        logic signed [VEC_W-1:0] dv;
        du     = s.v >>> sh;
        dv     = s.u >>> sh;
        r.zero = s.zero;
        if (!s.v[VEC_W-1]) begin
            r.u = s.u + du;
            r.v = s.v - dv;
            r.z = s.z + atan;
        end else begin
            r.u = s.u - du;
            r.v = s.v + dv;
            r.z = s.z - atan;
        end
        return r;
    endfunction

    logic  r_valid;
    t_pair r_data;
    t_pair n_data;

    always_comb begin
        n_data.a = rotate(i_data.a, i_shift, i_atan);
        n_data.b = rotate(i_data.b, i_shift, i_atan);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
